// File: hdl/uart_tx_rx_ring_buffers_top_macros.svh
// Assertion macros shared by the UART ring buffer checker.
// Depends on nothing; included by files that assert.
`ifndef UART_TX_RX_RING_BUFFERS_TOP_MACROS_SVH
`define UART_TX_RX_RING_BUFFERS_TOP_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define UTRB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define UTRB_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/utrb_pkg.sv
// Package for the UART ring buffers: FIFO depth, widths, event and status codes.
// Depends on nothing; used by the top level and its checker.
package utrb_pkg;

  localparam int FIFO_DEPTH = 64;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int BYTE_W     = 8;
  localparam int LEVEL_W    = 7;
  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 2;

  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(FIFO_DEPTH);

  typedef enum logic [MODE_W-1:0] {
    MODE_PUT     = 2'd0,
    MODE_GET     = 2'd1,
    MODE_LINE_RX = 2'd2,
    MODE_TX_RDY  = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_PUT_FULL  = 2'd1,
    ST_GET_EMPTY = 2'd2,
    ST_RX_DROP   = 2'd3
  } status_t;

  // Result flags held while the memory read completes.
  typedef struct packed {
    logic                rd_ok;
    logic                sd_ok;
    logic [LEVEL_W-1:0]  rx_lvl;
    logic [LEVEL_W-1:0]  tx_lvl;
    logic                drain;
    status_t             status;
  } pend_t;

  function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

// File: hdl/uart_tx_rx_ring_buffers_top.sv
// UART transmit and receive ring FIFOs, each a synchronous single-port-per-side memory.
// From input transaction to result: memory read, then output register.
// Throughput: one event per cycle while out_ready is high; the output register and the
// pending stage let a new event enter while a result waits.
// Reset: synchronous active-low rst_n clears pointers, counts, drain enable and valids;
// memory contents are not cleared, so no clearing pass is needed.
module uart_tx_rx_ring_buffers_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [utrb_pkg::MODE_W-1:0]    in_mode,
  input  logic [utrb_pkg::BYTE_W-1:0]    in_data_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [utrb_pkg::BYTE_W-1:0]    out_read_byte,
  output logic                           out_read_valid,
  output logic [utrb_pkg::BYTE_W-1:0]    out_send_byte,
  output logic                           out_send_valid,
  output logic [utrb_pkg::LEVEL_W-1:0]   out_rx_level,
  output logic [utrb_pkg::LEVEL_W-1:0]   out_tx_level,
  output logic                           out_drain_enabled,
  output logic [utrb_pkg::STATUS_W-1:0]  out_status
);
  import utrb_pkg::*;

  logic [BYTE_W-1:0] tx_mem [FIFO_DEPTH];
  logic [BYTE_W-1:0] rx_mem [FIFO_DEPTH];

  logic [PTR_W-1:0] tx_head_r, tx_head_nxt, tx_tail_r, tx_tail_nxt;
  logic [PTR_W-1:0] rx_head_r, rx_head_nxt, rx_tail_r, rx_tail_nxt;
  logic [CNT_W-1:0] tx_cnt_r, tx_cnt_nxt, rx_cnt_r, rx_cnt_nxt;
  logic             drain_r, drain_nxt;

  logic [BYTE_W-1:0] tx_rdata_r, rx_rdata_r;
  logic              tx_we, rx_we;

  pend_t pend_r, pend_nxt;
  logic  pend_vld_r;

  logic                out_vld_r;
  logic [BYTE_W-1:0]   out_rd_byte_r, out_sd_byte_r;
  pend_t               out_info_r;

  logic    in_fire, out_load;
  mode_t   mode;
  status_t status;
  logic    rd_ok, sd_ok;

  assign mode     = mode_t'(in_mode);
  assign out_load = pend_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !pend_vld_r || out_load;
  assign in_fire  = in_valid && in_ready;

  // Event decode: pointer, count and drain updates.
  always_comb begin
    tx_head_nxt = tx_head_r;
    tx_tail_nxt = tx_tail_r;
    rx_head_nxt = rx_head_r;
    rx_tail_nxt = rx_tail_r;
    tx_cnt_nxt  = tx_cnt_r;
    rx_cnt_nxt  = rx_cnt_r;
    drain_nxt   = drain_r;
    tx_we       = 1'b0;
    rx_we       = 1'b0;
    rd_ok       = 1'b0;
    sd_ok       = 1'b0;
    status      = ST_OK;
    case (mode)
      MODE_PUT: begin
        if (tx_cnt_r == CNT_FULL) begin
          status = ST_PUT_FULL;
        end else begin
          tx_we       = 1'b1;
          tx_head_nxt = ptr_adv(tx_head_r);
          tx_cnt_nxt  = tx_cnt_r + CNT_W'(1);
          drain_nxt   = 1'b1;
        end
      end
      MODE_GET: begin
        if (rx_cnt_r == '0) begin
          status = ST_GET_EMPTY;
        end else begin
          rd_ok       = 1'b1;
          rx_tail_nxt = ptr_adv(rx_tail_r);
          rx_cnt_nxt  = rx_cnt_r - CNT_W'(1);
        end
      end
      MODE_LINE_RX: begin
        if (rx_cnt_r == CNT_FULL) begin
          status = ST_RX_DROP;
        end else begin
          rx_we       = 1'b1;
          rx_head_nxt = ptr_adv(rx_head_r);
          rx_cnt_nxt  = rx_cnt_r + CNT_W'(1);
        end
      end
      MODE_TX_RDY: begin
        if (drain_r) begin
          if (tx_cnt_r != '0) begin
            sd_ok       = 1'b1;
            tx_tail_nxt = ptr_adv(tx_tail_r);
            tx_cnt_nxt  = tx_cnt_r - CNT_W'(1);
          end else begin
            drain_nxt = 1'b0;
          end
        end
      end
      default: status = ST_OK;
    endcase
  end

  always_comb begin
    pend_nxt.rd_ok  = rd_ok;
    pend_nxt.sd_ok  = sd_ok;
    pend_nxt.rx_lvl = LEVEL_W'(rx_cnt_nxt);
    pend_nxt.tx_lvl = LEVEL_W'(tx_cnt_nxt);
    pend_nxt.drain  = drain_nxt;
    pend_nxt.status = status;
  end

  // Memories: write at head, read at tail; a popped entry was always written
  // at an earlier edge, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (in_fire && tx_we) begin
      tx_mem[tx_head_r] <= in_data_byte;
    end
    if (in_fire) begin
      tx_rdata_r <= tx_mem[tx_tail_r];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && rx_we) begin
      rx_mem[rx_head_r] <= in_data_byte;
    end
    if (in_fire) begin
      rx_rdata_r <= rx_mem[rx_tail_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_head_r  <= '0;
      tx_tail_r  <= '0;
      rx_head_r  <= '0;
      rx_tail_r  <= '0;
      tx_cnt_r   <= '0;
      rx_cnt_r   <= '0;
      drain_r    <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        tx_head_r <= tx_head_nxt;
        tx_tail_r <= tx_tail_nxt;
        rx_head_r <= rx_head_nxt;
        rx_tail_r <= rx_tail_nxt;
        tx_cnt_r  <= tx_cnt_nxt;
        rx_cnt_r  <= rx_cnt_nxt;
        drain_r   <= drain_nxt;
      end
      if (in_fire) begin
        pend_vld_r <= 1'b1;
      end else if (out_load) begin
        pend_vld_r <= 1'b0;
      end
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_r <= pend_nxt;
    end
    if (out_load) begin
      out_info_r    <= pend_r;
      out_rd_byte_r <= pend_r.rd_ok ? rx_rdata_r : '0;
      out_sd_byte_r <= pend_r.sd_ok ? tx_rdata_r : '0;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_read_byte     = out_rd_byte_r;
  assign out_read_valid    = out_info_r.rd_ok;
  assign out_send_byte     = out_sd_byte_r;
  assign out_send_valid    = out_info_r.sd_ok;
  assign out_rx_level      = out_info_r.rx_lvl;
  assign out_tx_level      = out_info_r.tx_lvl;
  assign out_drain_enabled = out_info_r.drain;
  assign out_status        = out_info_r.status;

endmodule

// File: hdl/utrb_checker.sv
// Port-level checker for the UART ring buffer top level, bound to it below.
// Depends on utrb_pkg and the shared assertion macro header.
`include "uart_tx_rx_ring_buffers_top_macros.svh"

module utrb_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic [utrb_pkg::BYTE_W-1:0]    out_read_byte,
  input logic                           out_read_valid,
  input logic                           out_send_valid,
  input logic                           out_drain_enabled,
  input logic [utrb_pkg::LEVEL_W-1:0]   out_tx_level,
  input logic [utrb_pkg::STATUS_W-1:0]  out_status
);
  import utrb_pkg::*;

  localparam logic [LEVEL_W-1:0] LVL_FULL = LEVEL_W'(FIFO_DEPTH);

  // Nothing leaves the block in the cycle after reset.
  `UTRB_ASSERT_ALWAYS(a_no_out_after_rst, clk, $past(!rst_n) |-> !out_valid, "out_valid after reset")

  // A transaction that sends a byte leaves the drain enabled.
  `UTRB_ASSERT(a_send_keeps_drain, clk, rst_n, (out_valid && out_send_valid) |-> out_drain_enabled, "send with drain off")

  // A rejected put only happens on a full transmit FIFO.
  `UTRB_ASSERT(a_put_full_level, clk, rst_n, (out_valid && out_status == ST_PUT_FULL) |-> (out_tx_level == LVL_FULL && out_drain_enabled), "put rejected while tx not full")

  // Bytes are reported as zero unless popped, and a popped byte means a clean get.
  `UTRB_ASSERT(a_read_byte_zero, clk, rst_n, (out_valid && !out_read_valid) |-> (out_read_byte == '0), "read_byte non-zero without read_valid")

  `UTRB_ASSERT(a_read_send_excl, clk, rst_n, (out_valid && out_read_valid) |-> (!out_send_valid && out_status == ST_OK), "read result with send or bad status")

endmodule

bind uart_tx_rx_ring_buffers_top utrb_checker u_utrb_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_read_byte     (out_read_byte),
  .out_read_valid    (out_read_valid),
  .out_send_valid    (out_send_valid),
  .out_drain_enabled (out_drain_enabled),
  .out_tx_level      (out_tx_level),
  .out_status        (out_status)
);
